[hw/rtl/vgfs_pkg.sv]
// Shared constants, command and status codes for the voxel grid front-surface block.
package vgfs_pkg;

    localparam int GRID_DEFAULT = 64;   // voxels along each axis
    localparam int ROW_W        = 64;   // width of the result rows
    localparam int COORD_W      = 8;    // signed point coordinate
    localparam int CMD_W        = 2;
    localparam int STAT_W       = 2;
    localparam int SRC_W        = 10;   // signed source coordinate after centering
    localparam int S_TDATA_W    = 32;   // cmd, x, y, z padded to bytes
    localparam int M_TDATA_W    = 136;  // status, full_row, side_row padded to bytes

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR = 2'd0,
        CMD_ADD   = 2'd1,
        CMD_READ  = 2'd2
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_DROP    = 2'd1,
        STAT_OUTSIDE = 2'd2
    } stat_t;

endpackage

[hw/rtl/vgfs_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module vgfs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/voxel_grid_front_surface_centering_core.sv]
// Voxel grid front-surface centering core: occupancy grid, bounding box and centered column reads.
//
// The block keeps a GRID x GRID x GRID occupancy grid, one GRID-bit depth row per (x, y) column,
// in a single RAM of GRID*GRID rows, plus the occupied voxels' x-y box and lowest depth in flip-flops.
// Each input beat carries a command: clear, add a point, or read one column of the centered grid.
// Every beat yields exactly one result beat. An add outside the grid is dropped with status 1.
// A read shifts x and y so the bounding-box midpoint sits at GRID/2 and shifts depth so the
// lowest occupied depth lands at bit 0; full_row is the shifted occupancy row and side_row holds
// only its lowest set bit, which is the column's front surface. A read whose output or source
// column falls outside the grid returns status 2 and zero rows.
// Steps: an in-grid add or a read goes from acceptance to a result in the output register
// as accept and issue the RAM read, read-modify-write or shift the row, then load the output
// register; the single RAM port pair and its registered read data set these steps. A dropped
// add or an unused command skips the RAM step. One item is in flight at a time. A clear walks
// every RAM row, one per cycle. After reset the same clearing pass runs before s_tready first
// rises. The output register lets the next beat be accepted while a result still waits for
// m_tready.
module voxel_grid_front_surface_centering_core
    import vgfs_pkg::*;
#(
    parameter int GRID = GRID_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // [1:0] cmd, [9:2] coord_x, [17:10] coord_y, [25:18] coord_z, [31:26] zero
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // [1:0] status, [65:2] full_row, [129:66] side_row, [135:130] zero
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CELLS = GRID * GRID;
    localparam int AW    = $clog2(CELLS);   // RAM row address
    localparam int ZW    = $clog2(GRID);    // in-grid coordinate
    localparam int BW    = $clog2(GRID + 1); // box register, holds GRID when empty

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC,
        S_RESP
    } state_t;

    // Registers
    state_t               state_reg, state_next;
    logic [AW-1:0]        clr_cnt_reg, clr_cnt_next;
    logic                 clr_resp_reg, clr_resp_next;   // clear came from a command
    logic [BW-1:0]        box_min_x_reg, box_min_x_next;
    logic [BW-1:0]        box_max_x_reg, box_max_x_next;
    logic [BW-1:0]        box_min_y_reg, box_min_y_next;
    logic [BW-1:0]        box_max_y_reg, box_max_y_next;
    logic [BW-1:0]        box_min_z_reg, box_min_z_next;
    cmd_t                 cmd_reg, cmd_next;
    logic                 ok_reg, ok_next;
    logic [AW-1:0]        addr_reg, addr_next;
    logic [ZW-1:0]        z_reg, z_next;
    logic [STAT_W-1:0]    res_stat_reg, res_stat_next;
    logic [ROW_W-1:0]     res_full_reg, res_full_next;
    logic [ROW_W-1:0]     res_side_reg, res_side_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [STAT_W-1:0]    m_stat_reg, m_stat_next;
    logic [ROW_W-1:0]     m_full_reg, m_full_next;
    logic [ROW_W-1:0]     m_side_reg, m_side_next;

    // Input beat fields
    logic [CMD_W-1:0]          in_cmd;
    logic signed [COORD_W-1:0] in_x, in_y, in_z;
    logic                      in_x_ok, in_y_ok, in_z_ok;
    logic                      s_accept;

    // Centering
    logic [BW:0]               sum_x, sum_y;
    logic [BW-1:0]             mid_x, mid_y;
    logic signed [SRC_W-1:0]   src_x, src_y;
    logic                      src_ok;
    logic [AW-1:0]             col_add, col_read;

    // RAM
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr, ram_raddr;
    logic [GRID-1:0]           ram_wdata, ram_rdata;

    logic [ROW_W-1:0]          full_v, side_v;

    assign in_cmd = s_tdata[1:0];
    assign in_x   = s_tdata[9:2];
    assign in_y   = s_tdata[17:10];
    assign in_z   = s_tdata[25:18];

    assign in_x_ok = (in_x >= 0) && (in_x < GRID);
    assign in_y_ok = (in_y >= 0) && (in_y < GRID);
    assign in_z_ok = (in_z >= 0) && (in_z < GRID);

    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;

    // Box midpoint; an empty box sums to GRID and gives no shift.
    assign sum_x = (BW+1)'(box_max_x_reg) + (BW+1)'(box_min_x_reg);
    assign sum_y = (BW+1)'(box_max_y_reg) + (BW+1)'(box_min_y_reg);
    assign mid_x = sum_x[BW:1];
    assign mid_y = sum_y[BW:1];

    assign src_x = SRC_W'(in_x) - SRC_W'(GRID / 2) + SRC_W'(mid_x);
    assign src_y = SRC_W'(in_y) - SRC_W'(GRID / 2) + SRC_W'(mid_y);
    assign src_ok = (src_x >= 0) && (src_x < GRID) && (src_y >= 0) && (src_y < GRID);

    assign col_add  = AW'(AW'(in_x[ZW-1:0]) * AW'(GRID) + AW'(in_y[ZW-1:0]));
    assign col_read = AW'(AW'(src_x[ZW-1:0]) * AW'(GRID) + AW'(src_y[ZW-1:0]));

    // Read issues straight from the accepted beat; write happens in clear or add execution.
    assign ram_raddr = (in_cmd == CMD_READ) ? col_read : col_add;
    assign ram_we    = (state_reg == S_CLEAR) ||
                       ((state_reg == S_EXEC) && (cmd_reg == CMD_ADD) && ok_reg);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_cnt_reg : addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : (ram_rdata | (GRID'(1) << z_reg));

    // Shift depth so the lowest occupied depth sits at bit 0; keep the lowest set bit for side.
    assign full_v = ROW_W'(ram_rdata) >> box_min_z_reg;
    assign side_v = full_v & (~full_v + ROW_W'(1));

    vgfs_ram #(
        .WIDTH (GRID),
        .DEPTH (CELLS)
    ) u_rows (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        clr_cnt_next   = clr_cnt_reg;
        clr_resp_next  = clr_resp_reg;
        box_min_x_next = box_min_x_reg;
        box_max_x_next = box_max_x_reg;
        box_min_y_next = box_min_y_reg;
        box_max_y_next = box_max_y_reg;
        box_min_z_next = box_min_z_reg;
        cmd_next       = cmd_reg;
        ok_next        = ok_reg;
        addr_next      = addr_reg;
        z_next         = z_reg;
        res_stat_next  = res_stat_reg;
        res_full_next  = res_full_reg;
        res_side_next  = res_side_reg;
        m_tvalid_next  = m_tvalid_reg;
        m_stat_next    = m_stat_reg;
        m_full_next    = m_full_reg;
        m_side_next    = m_side_reg;

        // Drop the output beat once taken.
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(CELLS - 1)) begin
                    clr_cnt_next  = '0;
                    res_stat_next = STAT_DONE;
                    res_full_next = '0;
                    res_side_next = '0;
                    state_next    = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_accept) begin
                    cmd_next      = cmd_t'(in_cmd);
                    z_next        = in_z[ZW-1:0];
                    res_stat_next = STAT_DONE;
                    res_full_next = '0;
                    res_side_next = '0;
                    case (in_cmd)
                        CMD_CLEAR: begin
                            box_min_x_next = BW'(GRID);
                            box_max_x_next = '0;
                            box_min_y_next = BW'(GRID);
                            box_max_y_next = '0;
                            box_min_z_next = BW'(GRID);
                            clr_cnt_next   = '0;
                            clr_resp_next  = 1'b1;
                            state_next     = S_CLEAR;
                        end
                        CMD_ADD: begin
                            ok_next   = in_x_ok && in_y_ok && in_z_ok;
                            addr_next = col_add;
                            if (in_x_ok && in_y_ok && in_z_ok) begin
                                if (BW'(in_x[ZW-1:0]) < box_min_x_reg) begin
                                    box_min_x_next = BW'(in_x[ZW-1:0]);
                                end
                                if (BW'(in_x[ZW-1:0]) > box_max_x_reg) begin
                                    box_max_x_next = BW'(in_x[ZW-1:0]);
                                end
                                if (BW'(in_y[ZW-1:0]) < box_min_y_reg) begin
                                    box_min_y_next = BW'(in_y[ZW-1:0]);
                                end
                                if (BW'(in_y[ZW-1:0]) > box_max_y_reg) begin
                                    box_max_y_next = BW'(in_y[ZW-1:0]);
                                end
                                if (BW'(in_z[ZW-1:0]) < box_min_z_reg) begin
                                    box_min_z_next = BW'(in_z[ZW-1:0]);
                                end
                                state_next = S_EXEC;
                            end else begin
                                res_stat_next = STAT_DROP;
                                state_next    = S_RESP;
                            end
                        end
                        CMD_READ: begin
                            ok_next    = in_x_ok && in_y_ok && src_ok;
                            addr_next  = col_read;
                            state_next = S_EXEC;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                // Add writes back through ram_we; read shapes the row.
                if (cmd_reg == CMD_READ) begin
                    if (ok_reg) begin
                        res_full_next = full_v;
                        res_side_next = side_v;
                    end else begin
                        res_stat_next = STAT_OUTSIDE;
                    end
                end
                state_next = S_RESP;
            end
            S_RESP: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_stat_next   = res_stat_reg;
                    m_full_next   = res_full_reg;
                    m_side_next   = res_side_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            clr_resp_reg  <= 1'b0;
            box_min_x_reg <= BW'(GRID);
            box_max_x_reg <= '0;
            box_min_y_reg <= BW'(GRID);
            box_max_y_reg <= '0;
            box_min_z_reg <= BW'(GRID);
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            clr_resp_reg  <= clr_resp_next;
            box_min_x_reg <= box_min_x_next;
            box_max_x_reg <= box_max_x_next;
            box_min_y_reg <= box_min_y_next;
            box_max_y_reg <= box_max_y_next;
            box_min_z_reg <= box_min_z_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        cmd_reg      <= cmd_next;
        ok_reg       <= ok_next;
        addr_reg     <= addr_next;
        z_reg        <= z_next;
        res_stat_reg <= res_stat_next;
        res_full_reg <= res_full_next;
        res_side_reg <= res_side_next;
        m_stat_reg   <= m_stat_next;
        m_full_reg   <= m_full_next;
        m_side_reg   <= m_side_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - STAT_W - 2 * ROW_W){1'b0}}, m_side_reg, m_full_reg, m_stat_reg};

    // A nonempty box always has min <= max.
    a_box_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (box_min_x_reg != BW'(GRID)) |-> (box_min_x_reg <= box_max_x_reg) &&
                                         (box_min_y_reg <= box_max_y_reg))
        else $error("bounding box min above max");

    // The x and z box minima go empty and nonempty together.
    a_box_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (box_min_x_reg == BW'(GRID)) == (box_min_z_reg == BW'(GRID)))
        else $error("bounding box axes disagree on emptiness");

    // Only a clear sweep or an in-grid add writes the row memory.
    a_ram_write: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg == S_CLEAR) ||
                   ((state_reg == S_EXEC) && (cmd_reg == CMD_ADD) && ok_reg))
        else $error("unexpected row memory write");

    // A clear command starts its sweep at row zero.
    a_clear_start: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (in_cmd == CMD_CLEAR)) |=> (state_reg == S_CLEAR) && (clr_cnt_reg == '0))
        else $error("clear sweep did not start at row zero");

    // A new output beat comes only from the response state.
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && !$past(m_tvalid_reg && !m_tready) && $past(aresetn))
            |-> $past(state_reg == S_RESP))
        else $error("output beat loaded outside response state");

endmodule

[test/voxel_grid_front_surface_centering_core_test.sv]
// Self-checking stream testbench for the voxel grid front-surface centering core.
module voxel_grid_front_surface_centering_core_test
    import vgfs_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int GRID        = GRID_DEFAULT;
    localparam int CELLS       = GRID * GRID;
    localparam int QUIET_LIMIT = 4 * CELLS + 1000;   // a clear walks every row once
    localparam int PHASE_BEATS = 108;
    localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;   // unused opcode, must be a no-op

    typedef struct {
        logic [STAT_W-1:0] status;
        logic [ROW_W-1:0]  full_row;
        logic [ROW_W-1:0]  side_row;
    } voxel_row_t;

    typedef enum int {GAP_NONE, GAP_SEND, GAP_RECV, GAP_BOTH} gap_mode_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [1:0] cmd, [9:2] coord_x, [17:10] coord_y, [25:18] coord_z, [31:26] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [1:0] status, [65:2] full_row, [129:66] side_row, [135:130] zero
    logic [M_TDATA_W-1:0] m_tdata;

    gap_mode_t            gap_mode = GAP_NONE;
    logic [S_TDATA_W-1:0] beat_q[$];       // beats waiting for the driver
    voxel_row_t           row_expect[$];   // predicted result beats, oldest first
    int                   mismatch_count = 0;
    int                   quiet_cycles   = 0;

    // Predicted grid contents, front surface and bounding box.
    logic [ROW_W-1:0] vox_rows [CELLS];
    logic [6:0]       vox_front[CELLS];
    logic [6:0]       bb_min_x, bb_max_x, bb_min_y, bb_max_y, bb_min_z;

    // Stimulus-side view of the box, so reads can be aimed at occupied columns.
    int plan_min_x, plan_max_x, plan_min_y, plan_max_y;
    int plan_cols[$];

    voxel_grid_front_surface_centering_core #(
        .GRID(GRID)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic bit on_grid(input int v);
        return v >= 0 && v < GRID;
    endfunction

    function automatic void wipe_grid();
        foreach (vox_rows[i]) begin
            vox_rows[i]  = '0;
            vox_front[i] = 7'(GRID);
        end
        bb_min_x = 7'(GRID);
        bb_max_x = '0;
        bb_min_y = 7'(GRID);
        bb_max_y = '0;
        bb_min_z = 7'(GRID);
    endfunction

    // Work out the result of one accepted command beat and advance the grid.
    function automatic void fold_beat(input logic [S_TDATA_W-1:0] beat);
        int         x, y, z, sx, sy, col, mz, fd;
        voxel_row_t r;
        x = int'($signed(beat[9:2]));
        y = int'($signed(beat[17:10]));
        z = int'($signed(beat[25:18]));
        r.status   = STAT_DONE;
        r.full_row = '0;
        r.side_row = '0;
        case (beat[1:0])
            CMD_CLEAR: wipe_grid();
            CMD_ADD: begin
                if (!on_grid(x) || !on_grid(y) || !on_grid(z)) begin
                    r.status = STAT_DROP;
                end else begin
                    col = x * GRID + y;
                    vox_rows[col][z] = 1'b1;
                    if (z < vox_front[col]) vox_front[col] = 7'(z);
                    if (x < bb_min_x) bb_min_x = 7'(x);
                    if (x > bb_max_x) bb_max_x = 7'(x);
                    if (y < bb_min_y) bb_min_y = 7'(y);
                    if (y > bb_max_y) bb_max_y = 7'(y);
                    if (z < bb_min_z) bb_min_z = 7'(z);
                end
            end
            CMD_READ: begin
                // shift so the box midpoint lands on the grid center
                sx = x - GRID / 2 + (int'(bb_max_x) + int'(bb_min_x)) / 2;
                sy = y - GRID / 2 + (int'(bb_max_y) + int'(bb_min_y)) / 2;
                if (!on_grid(x) || !on_grid(y) || !on_grid(sx) || !on_grid(sy)) begin
                    r.status = STAT_OUTSIDE;
                end else begin
                    col = sx * GRID + sy;
                    mz  = int'(bb_min_z);
                    fd  = int'(vox_front[col]);
                    if (mz < ROW_W) r.full_row = vox_rows[col] >> mz;
                    if (fd < GRID && fd >= mz && fd - mz < ROW_W)
                        r.side_row = 64'd1 << (fd - mz);
                end
            end
            default: ;   // spare opcode: nothing changes
        endcase
        row_expect.insert(row_expect.size(), r);
    endfunction

    // Queue one command beat and keep the stimulus-side box in step with it.
    function automatic void plan(input logic [CMD_W-1:0] op, input int x, input int y,
                                 input int z);
        beat_q.insert(beat_q.size(), {6'b0, 8'(z), 8'(y), 8'(x), op});
        if (op == CMD_CLEAR) begin
            plan_min_x = GRID;
            plan_max_x = 0;
            plan_min_y = GRID;
            plan_max_y = 0;
            plan_cols.delete();
        end else if (op == CMD_ADD && on_grid(x) && on_grid(y) && on_grid(z)) begin
            if (x < plan_min_x) plan_min_x = x;
            if (x > plan_max_x) plan_max_x = x;
            if (y < plan_min_y) plan_min_y = y;
            if (y > plan_max_y) plan_max_y = y;
            plan_cols.insert(plan_cols.size(), x * GRID + y);
        end
    endfunction

    function automatic bit send_gap();
        case (gap_mode)
            GAP_SEND: return $urandom_range(0, 99) < 59;
            GAP_BOTH: return $urandom_range(0, 99) < 21;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic bit recv_stall();
        case (gap_mode)
            GAP_RECV: return $urandom_range(0, 99) < 59;
            GAP_BOTH: return $urandom_range(0, 99) < 21;
            default:  return 1'b0;
        endcase
    endfunction

    // Driver: present the next beat once the current one is taken, or idle.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else if (!s_tvalid || s_tready) begin
            if (beat_q.size() != 0 && !send_gap()) begin
                s_tvalid <= 1'b1;
                s_tdata  <= beat_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: predict on each accepted command beat, check each result beat.
    // Both are sampled here so that prediction always precedes its check.
    always @(posedge aclk) begin
        voxel_row_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) fold_beat(s_tdata);
            if (m_tvalid && m_tready) begin
                if (row_expect.size() == 0) begin
                    if (mismatch_count < 10)
                        $display("%0t: unexpected result beat %h", $realtime, m_tdata);
                    mismatch_count++;
                end else begin
                    want = row_expect.pop_front();
                    if (m_tdata[1:0] !== want.status || m_tdata[65:2] !== want.full_row ||
                        m_tdata[129:66] !== want.side_row) begin
                        if (mismatch_count < 10)
                            $display("%0t: status %0d/%0d full %h/%h side %h/%h (exp/got)",
                                     $realtime, want.status, m_tdata[1:0], want.full_row,
                                     m_tdata[65:2], want.side_row, m_tdata[129:66]);
                        mismatch_count++;
                    end
                end
            end
            m_tready <= !recv_stall();

            // watchdog: the only slow path is a clear, far below the limit
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // Hold until every queued beat is taken and every result has come back.
    task automatic drain_all();
        do @(negedge aclk);
        while (beat_q.size() != 0 || s_tvalid || row_expect.size() != 0);
    endtask

    initial begin
        int roll, cx, cy, col, ox, oy;
        wipe_grid();
        plan_min_x = GRID;
        plan_max_x = 0;
        plan_min_y = GRID;
        plan_max_y = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty read, every drop reason, centering, spare opcode, clear.
        plan(CMD_READ, 5, 7, 0);
        plan(CMD_ADD, -128, 0, 0);
        plan(CMD_ADD, 0, 127, 0);
        plan(CMD_ADD, 0, 0, 64);
        plan(CMD_ADD, 0, 0, -1);
        plan(CMD_ADD, 64, 5, 5);
        plan(CMD_ADD, 10, 20, 30);
        plan(CMD_ADD, 10, 20, 40);
        plan(CMD_ADD, 12, 22, 35);
        plan(CMD_READ, 31, 31, -128);
        plan(CMD_READ, 33, 33, 127);
        plan(CMD_READ, -1, 31, 0);
        plan(CMD_READ, 31, 64, 0);
        plan(CMD_READ, 127, -128, 0);
        plan(CMD_SPARE, -1, -1, -1);
        plan(CMD_ADD, 0, 0, 0);
        plan(CMD_ADD, 63, 63, 63);
        plan(CMD_READ, 0, 0, 0);      // source column falls off the low edge
        plan(CMD_READ, 1, 1, 0);
        plan(CMD_READ, 11, 21, 0);
        plan(CMD_READ, 63, 63, 0);
        plan(CMD_CLEAR, 0, 0, 0);
        plan(CMD_READ, 11, 21, 0);
        plan(CMD_ADD, 63, 0, 1);      // single point: box pins to the far corner
        plan(CMD_READ, 32, 32, 0);
        drain_all();

        // Random phases, one per idling pattern, each on a fresh grid.
        for (int phase = 0; phase < 4; phase++) begin
            gap_mode = gap_mode_t'(phase);
            plan(CMD_CLEAR, 0, 0, 0);
            cx = $urandom_range(0, GRID - 7);
            cy = $urandom_range(0, GRID - 7);
            for (int n = 0; n < PHASE_BEATS; n++) begin
                roll = $urandom_range(0, 99);
                if (roll < 45) begin
                    // clustered points so that columns fill up with several depths
                    plan(CMD_ADD, cx + $urandom_range(0, 6), cy + $urandom_range(0, 6),
                         $urandom_range(0, GRID - 1));
                end else if (roll < 55) begin
                    plan(CMD_ADD, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                         $urandom_range(0, GRID - 1));
                end else if (roll < 63) begin
                    plan(CMD_ADD, int'($signed(8'($urandom))), int'($signed(8'($urandom))),
                         int'($signed(8'($urandom))));
                end else if (roll < 88 && plan_cols.size() != 0) begin
                    // aim at an occupied column through the current centering shift
                    col = plan_cols[$urandom_range(0, plan_cols.size() - 1)];
                    ox  = col / GRID - (plan_max_x + plan_min_x) / 2 + GRID / 2;
                    oy  = col % GRID - (plan_max_y + plan_min_y) / 2 + GRID / 2;
                    if ($urandom_range(0, 3) == 0) begin
                        ox += int'($urandom_range(0, 2)) - 1;
                        oy += int'($urandom_range(0, 2)) - 1;
                    end
                    plan(CMD_READ, ox, oy, int'($signed(8'($urandom))));
                end else if (roll < 96) begin
                    if ($urandom_range(0, 1) == 0)
                        plan(CMD_READ, $urandom_range(0, GRID - 1), $urandom_range(0, GRID - 1),
                             0);
                    else
                        plan(CMD_READ, int'($signed(8'($urandom))), int'($signed(8'($urandom))),
                             int'($signed(8'($urandom))));
                end else if (roll < 99) begin
                    plan(CMD_SPARE, int'($signed(8'($urandom))), int'($signed(8'($urandom))),
                         int'($signed(8'($urandom))));
                end else begin
                    plan(CMD_CLEAR, int'($signed(8'($urandom))), 0, 0);
                end
            end
            drain_all();
        end

        // let any stray beat show up before the verdict
        repeat (8) @(negedge aclk);
        if (mismatch_count == 0 && row_expect.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/vgfs_pkg.sv
hw/rtl/vgfs_ram.sv
hw/rtl/voxel_grid_front_surface_centering_core.sv
test/voxel_grid_front_surface_centering_core_test.sv
